[rtl/erfinv_pkg.sv]
// Shared constants, types and coefficient tables of the inverse error function pipeline.
package erfinv_pkg;

   localparam int IN_FRAC_BITS  = 32;
   localparam int OUT_FRAC_BITS = 28;
   localparam int ARG_W         = IN_FRAC_BITS + 1;
   localparam int U_W           = 32;
   localparam int RES_W         = 32;
   localparam int QF            = 48;
   localparam int SQ_STEPS      = QF;
   localparam int ROOT_W        = 53;
   localparam int RADICAND_W    = 2 * ROOT_W;
   localparam int REM_W         = ROOT_W + 4;
   localparam int TERMS         = 9;
   localparam int OUT_SHIFT     = QF + U_W - OUT_FRAC_BITS;

   typedef logic signed [63:0] q_type;

   typedef struct packed {
      logic           sat;
      logic           zero;
      logic [U_W-1:0] u;
   } tag_type;

   // Nearest Q.48 value of a signed decimal mant * 10^-exp10.
   function automatic q_type dec_to_q(input logic neg, input logic [63:0] mant,
                                      input int exp10);
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] q;
      logic        b;
      den = 64'd1;
      rem = '0;
      q   = '0;
      for (int i = 0; i < exp10; i++) den = den * 64'd10;
      for (int i = 64 + QF - 1; i >= 0; i--) begin
         b = 1'b0;
         if (i >= QF) b = mant[i - QF];
         rem = {rem[62:0], b};
         q   = {q[62:0], 1'b0};
         if (rem >= den) begin
            rem  = rem - den;
            q[0] = 1'b1;
         end
      end
      if (rem >= den - rem) q = q + 64'd1;
      return neg ? q_type'(64'd0 - q) : q_type'(q);
   endfunction

   localparam q_type NEAR_Q [TERMS] = '{
      dec_to_q(1'b0, 64'd281022636, 16), dec_to_q(1'b0, 64'd343273939, 15),
      dec_to_q(1'b1, 64'd352338770, 14), dec_to_q(1'b1, 64'd439150654, 14),
      dec_to_q(1'b0, 64'd21858087, 11),  dec_to_q(1'b1, 64'd125372503, 11),
      dec_to_q(1'b1, 64'd417768164, 11), dec_to_q(1'b0, 64'd246640727, 9),
      dec_to_q(1'b0, 64'd150140941, 8)
   };

   localparam q_type TAIL_Q [TERMS] = '{
      dec_to_q(1'b1, 64'd200214257, 12), dec_to_q(1'b0, 64'd100950558, 12),
      dec_to_q(1'b0, 64'd134934322, 11), dec_to_q(1'b1, 64'd367342844, 11),
      dec_to_q(1'b0, 64'd573950773, 11), dec_to_q(1'b1, 64'd76224613, 10),
      dec_to_q(1'b0, 64'd943887047, 11), dec_to_q(1'b0, 64'd100167406, 8),
      dec_to_q(1'b0, 64'd283297682, 8)
   };

   localparam q_type LN2_Q   = dec_to_q(1'b0, 64'd6931471805599453, 16);
   localparam q_type FIVE_Q  = q_type'(64'd5 << QF);
   localparam q_type HALF5_Q = q_type'(64'd5 << (QF - 1));
   localparam q_type THREE_Q = q_type'(64'd3 << QF);

endpackage

[rtl/inverse_error_function.sv]
// Top level of the pipelined inverse error function.
//
// The req channel takes one argument beat per cycle: req_arg_value is x in
// unsigned Q1.32, where the pattern with only the top bit set means 1.0.
// The rsp channel returns erfinv(x) in unsigned Q4.28 on rsp_result_value.
// Any argument of 1.0 or above gives the all-ones value with rsp_saturated
// set, and so does a result too large for the output format.
// The pipeline holds 184 register stages. The stage count is set by the
// 48 two-stage squarings of the logarithm and the 53 stages of the
// bit-per-stage square root. A new beat is accepted in every cycle in
// which the receiver does not stall the output.
// When the receiver holds rsp_ready low while a result waits, the whole
// pipeline freezes and req_ready falls; nothing is lost or repeated, and
// all in-flight beats resume when rsp_ready returns.
// A synchronous reset empties the pipeline; results that were in flight are
// dropped and the block is ready again on the next cycle.
module inverse_error_function (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [erfinv_pkg::ARG_W-1:0]    req_arg_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [erfinv_pkg::RES_W-1:0]    rsp_result_value,
   output logic                            rsp_saturated
);

   logic                adv;
   logic                log_valid;
   erfinv_pkg::tag_type log_tag;
   erfinv_pkg::q_type   log_w;
   logic                rt_valid;
   erfinv_pkg::tag_type rt_tag;
   logic                rt_near;
   erfinv_pkg::q_type   rt_d;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   erfinv_log u_log (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_arg    (req_arg_value),
      .out_valid (log_valid),
      .out_tag   (log_tag),
      .out_w     (log_w)
   );

   erfinv_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (log_valid),
      .in_tag    (log_tag),
      .in_w      (log_w),
      .out_valid (rt_valid),
      .out_tag   (rt_tag),
      .out_near  (rt_near),
      .out_d     (rt_d)
   );

   erfinv_poly u_poly (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (rt_valid),
      .in_tag        (rt_tag),
      .in_near       (rt_near),
      .in_d          (rt_d),
      .out_valid     (rsp_valid),
      .out_result    (rsp_result_value),
      .out_saturated (rsp_saturated)
   );

endmodule

[rtl/erfinv_qmul.sv]
// Two-stage signed Q.48 multiplier built from four 32x32 partial products.
module erfinv_qmul (
   input  logic               clock,
   input  logic               adv,
   input  erfinv_pkg::q_type  a,
   input  erfinv_pkg::q_type  b,
   output erfinv_pkg::q_type  y
);

   logic [63:0]  ua;
   logic [63:0]  ub;
   logic [63:0]  p00_ff;
   logic [63:0]  p01_ff;
   logic [63:0]  p10_ff;
   logic [63:0]  p11_ff;
   logic         neg_ff;
   logic [127:0] sum;
   logic [61:0]  mag;
   erfinv_pkg::q_type y_ff;

   assign ua = a[63] ? (64'd0 - $unsigned(a)) : $unsigned(a);
   assign ub = b[63] ? (64'd0 - $unsigned(b)) : $unsigned(b);

   always_ff @(posedge clock) begin
      if (adv) begin
         p00_ff <= ua[31:0]  * ub[31:0];
         p01_ff <= ua[31:0]  * ub[63:32];
         p10_ff <= ua[63:32] * ub[31:0];
         p11_ff <= ua[63:32] * ub[63:32];
         neg_ff <= a[63] ^ b[63];
      end
   end

   assign sum = {p11_ff, 64'd0} + {32'd0, p01_ff, 32'd0} + {32'd0, p10_ff, 32'd0}
              + {64'd0, p00_ff} + (128'd1 << (erfinv_pkg::QF - 1));
   assign mag = sum[erfinv_pkg::QF+61:erfinv_pkg::QF];

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= neg_ff ? erfinv_pkg::q_type'(64'd0 - {2'b00, mag})
                        : erfinv_pkg::q_type'({2'b00, mag});
      end
   end

   assign y = y_ff;

endmodule

[rtl/erfinv_log.sv]
// Front end: forms 1 - x^2, normalizes it and takes w = -ln(1 - x^2) by repeated squaring.
module erfinv_log (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [erfinv_pkg::ARG_W-1:0]      in_arg,
   output logic                              out_valid,
   output erfinv_pkg::tag_type               out_tag,
   output erfinv_pkg::q_type                 out_w
);

   localparam int SQ = erfinv_pkg::SQ_STEPS;
   localparam int QF = erfinv_pkg::QF;

   logic [erfinv_pkg::ARG_W+31:0] arg_ext;
   logic [erfinv_pkg::U_W-1:0]    u;
   logic [63:0]                   usq_in;
   logic                          v0_ff;
   erfinv_pkg::tag_type           tag0_ff;
   logic [63:0]                   usq0_ff;

   logic [63:0]         nrm_ff  [3];
   logic [5:0]          lz_ff   [3];
   logic                vn_ff   [3];
   erfinv_pkg::tag_type tagn_ff [3];

   logic [63:0]         p00_ff  [SQ];
   logic [62:0]         p01_ff  [SQ];
   logic [61:0]         p11_ff  [SQ];
   logic [QF-1:0]       fa_ff   [SQ];
   logic [5:0]          ea_ff   [SQ];
   erfinv_pkg::tag_type taga_ff [SQ];
   logic                va_ff   [SQ];
   logic [62:0]         mb_ff   [SQ];
   logic [QF-1:0]       fb_ff   [SQ];
   logic [5:0]          eb_ff   [SQ];
   erfinv_pkg::tag_type tagb_ff [SQ];
   logic                vb_ff   [SQ];

   logic [54:0]         aw_in;
   logic [54:0]         aw_ff;
   erfinv_pkg::tag_type tagw_ff;
   logic                vw_ff;
   erfinv_pkg::q_type   aw_ext;
   erfinv_pkg::tag_type tagq_ff [2];
   logic                vq_ff   [2];

   assign arg_ext = {in_arg, 32'd0};
   assign u       = arg_ext[erfinv_pkg::IN_FRAC_BITS +: erfinv_pkg::U_W];
   assign usq_in  = u * u;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag0_ff.sat  <= in_arg[erfinv_pkg::IN_FRAC_BITS];
         tag0_ff.zero <= (u == '0);
         tag0_ff.u    <= u;
         usq0_ff      <= usq_in;
      end
   end

   // Leading-zero normalization of 2^64 - u^2, two shift steps per stage.
   for (genvar g = 0; g < 3; g++) begin : g_nrm
      localparam int SH_HI = 32 >> (2 * g);
      localparam int SH_LO = 16 >> (2 * g);
      logic [63:0]         src;
      logic [5:0]          lz_src;
      logic                v_src;
      erfinv_pkg::tag_type tag_src;
      logic [63:0]         mid;
      logic [63:0]         nrm_in;
      logic [5:0]          lz_in;

      if (g == 0) begin : g_first
         assign src     = 64'd0 - usq0_ff;
         assign lz_src  = '0;
         assign v_src   = v0_ff;
         assign tag_src = tag0_ff;
      end else begin : g_next
         assign src     = nrm_ff[g-1];
         assign lz_src  = lz_ff[g-1];
         assign v_src   = vn_ff[g-1];
         assign tag_src = tagn_ff[g-1];
      end

      always_comb begin
         mid   = src;
         lz_in = lz_src;
         if (src[63 -: SH_HI] == '0) begin
            mid            = src << SH_HI;
            lz_in[5 - 2*g] = 1'b1;
         end
         nrm_in = mid;
         if (mid[63 -: SH_LO] == '0) begin
            nrm_in         = mid << SH_LO;
            lz_in[4 - 2*g] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vn_ff[g] <= 1'b0;
         end else if (adv) begin
            vn_ff[g] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nrm_ff[g]  <= nrm_in;
            lz_ff[g]   <= lz_in;
            tagn_ff[g] <= tag_src;
         end
      end
   end

   // One fraction bit of log2 per squaring, each squaring over two stages.
   for (genvar i = 0; i < SQ; i++) begin : g_sq
      logic [62:0]         m_src;
      logic [QF-1:0]       f_src;
      logic [5:0]          e_src;
      logic                v_src;
      erfinv_pkg::tag_type tag_src;
      logic [125:0]        sq;
      logic [63:0]         top;
      logic [62:0]         m_in;
      logic [QF-1:0]       f_in;

      if (i == 0) begin : g_first
         assign m_src   = nrm_ff[2][63:1];
         assign f_src   = '0;
         assign e_src   = ~lz_ff[2];
         assign v_src   = vn_ff[2];
         assign tag_src = tagn_ff[2];
      end else begin : g_next
         assign m_src   = mb_ff[i-1];
         assign f_src   = fb_ff[i-1];
         assign e_src   = eb_ff[i-1];
         assign v_src   = vb_ff[i-1];
         assign tag_src = tagb_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[i] <= 1'b0;
            vb_ff[i] <= 1'b0;
         end else if (adv) begin
            va_ff[i] <= v_src;
            vb_ff[i] <= va_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            p00_ff[i]  <= m_src[31:0]  * m_src[31:0];
            p01_ff[i]  <= m_src[31:0]  * m_src[62:32];
            p11_ff[i]  <= m_src[62:32] * m_src[62:32];
            fa_ff[i]   <= f_src;
            ea_ff[i]   <= e_src;
            taga_ff[i] <= tag_src;
         end
      end

      always_comb begin
         sq   = {p11_ff[i], 64'd0} + {30'd0, p01_ff[i], 33'd0} + {62'd0, p00_ff[i]};
         top  = sq[125:62];
         m_in = top[63] ? top[63:1] : top[62:0];
         f_in = fa_ff[i];
         f_in[QF-1-i] = top[63];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            mb_ff[i]   <= m_in;
            fb_ff[i]   <= f_in;
            eb_ff[i]   <= ea_ff[i];
            tagb_ff[i] <= taga_ff[i];
         end
      end
   end

   assign aw_in = {7'(7'd64 - {1'b0, eb_ff[SQ-1]}), {QF{1'b0}}} - {7'd0, fb_ff[SQ-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff    <= 1'b0;
         vq_ff[0] <= 1'b0;
         vq_ff[1] <= 1'b0;
      end else if (adv) begin
         vw_ff    <= vb_ff[SQ-1];
         vq_ff[0] <= vw_ff;
         vq_ff[1] <= vq_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         aw_ff      <= aw_in;
         tagw_ff    <= tagb_ff[SQ-1];
         tagq_ff[0] <= tagw_ff;
         tagq_ff[1] <= tagq_ff[0];
      end
   end

   assign aw_ext = erfinv_pkg::q_type'({9'd0, aw_ff});

   erfinv_qmul u_ln2_mul (
      .clock (clock),
      .adv   (adv),
      .a     (aw_ext),
      .b     (erfinv_pkg::LN2_Q),
      .y     (out_w)
   );

   assign out_valid = vq_ff[1];
   assign out_tag   = tagq_ff[1];

endmodule

[rtl/erfinv_sqrt.sv]
// Branch select and digit-by-digit square root, one root bit per stage; forms the polynomial argument.
module erfinv_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  erfinv_pkg::tag_type in_tag,
   input  erfinv_pkg::q_type   in_w,
   output logic                out_valid,
   output erfinv_pkg::tag_type out_tag,
   output logic                out_near,
   output erfinv_pkg::q_type   out_d
);

   localparam int RW = erfinv_pkg::ROOT_W;
   localparam int NW = erfinv_pkg::RADICAND_W;
   localparam int MW = erfinv_pkg::REM_W;
   localparam int QF = erfinv_pkg::QF;

   logic                v0_ff;
   logic                near0_ff;
   erfinv_pkg::q_type   w0_ff;
   logic [NW-1:0]       n0_ff;
   erfinv_pkg::tag_type tag0_ff;

   logic                vs_ff    [RW];
   logic                nears_ff [RW];
   erfinv_pkg::q_type   ws_ff    [RW];
   logic [NW-1:0]       ns_ff    [RW];
   logic [MW-1:0]       rs_ff    [RW];
   logic [RW-1:0]       roots_ff [RW];
   erfinv_pkg::tag_type tags_ff  [RW];

   logic                vd_ff;
   logic                neard_ff;
   erfinv_pkg::q_type   d_ff;
   erfinv_pkg::tag_type tagd_ff;
   erfinv_pkg::q_type   d_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         near0_ff <= (in_w < erfinv_pkg::FIVE_Q);
         w0_ff    <= in_w;
         n0_ff    <= {in_w[NW-QF-1:0], {QF{1'b0}}};
         tag0_ff  <= in_tag;
      end
   end

   for (genvar j = 0; j < RW; j++) begin : g_root
      logic                v_src;
      logic                near_src;
      erfinv_pkg::q_type   w_src;
      logic [NW-1:0]       n_src;
      logic [MW-1:0]       r_src;
      logic [RW-1:0]       root_src;
      erfinv_pkg::tag_type tag_src;
      logic [MW-1:0]       remx;
      logic [MW-1:0]       trial;
      logic                take;

      if (j == 0) begin : g_first
         assign v_src    = v0_ff;
         assign near_src = near0_ff;
         assign w_src    = w0_ff;
         assign n_src    = n0_ff;
         assign r_src    = '0;
         assign root_src = '0;
         assign tag_src  = tag0_ff;
      end else begin : g_next
         assign v_src    = vs_ff[j-1];
         assign near_src = nears_ff[j-1];
         assign w_src    = ws_ff[j-1];
         assign n_src    = ns_ff[j-1];
         assign r_src    = rs_ff[j-1];
         assign root_src = roots_ff[j-1];
         assign tag_src  = tags_ff[j-1];
      end

      assign remx  = {r_src[MW-3:0], n_src[NW-1:NW-2]};
      assign trial = {2'b00, root_src, 2'b01};
      assign take  = (remx >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[j] <= 1'b0;
         end else if (adv) begin
            vs_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nears_ff[j] <= near_src;
            ws_ff[j]    <= w_src;
            ns_ff[j]    <= {n_src[NW-3:0], 2'b00};
            rs_ff[j]    <= take ? (remx - trial) : remx;
            roots_ff[j] <= {root_src[RW-2:0], take};
            tags_ff[j]  <= tag_src;
         end
      end
   end

   assign d_in = nears_ff[RW-1]
               ? (ws_ff[RW-1] - erfinv_pkg::HALF5_Q)
               : (erfinv_pkg::q_type'({{(64-RW){1'b0}}, roots_ff[RW-1]})
                  - erfinv_pkg::THREE_Q);

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= vs_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neard_ff <= nears_ff[RW-1];
         d_ff     <= d_in;
         tagd_ff  <= tags_ff[RW-1];
      end
   end

   assign out_valid = vd_ff;
   assign out_tag   = tagd_ff;
   assign out_near  = neard_ff;
   assign out_d     = d_ff;

endmodule

[rtl/erfinv_poly.sv]
// Pipelined Horner evaluation of the selected polynomial, final scaling by x and result register.
module erfinv_poly (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  erfinv_pkg::tag_type             in_tag,
   input  logic                            in_near,
   input  erfinv_pkg::q_type               in_d,
   output logic                            out_valid,
   output logic [erfinv_pkg::RES_W-1:0]    out_result,
   output logic                            out_saturated
);

   localparam int NS = erfinv_pkg::TERMS - 1;
   localparam int SH = erfinv_pkg::OUT_SHIFT;

   logic                v1_ff    [NS];
   logic                v2_ff    [NS];
   logic                vh_ff    [NS];
   logic                near1_ff [NS];
   logic                near2_ff [NS];
   logic                nearh_ff [NS];
   erfinv_pkg::q_type   d1_ff    [NS];
   erfinv_pkg::q_type   d2_ff    [NS];
   erfinv_pkg::q_type   dh_ff    [NS];
   erfinv_pkg::tag_type tag1_ff  [NS];
   erfinv_pkg::tag_type tag2_ff  [NS];
   erfinv_pkg::tag_type tagh_ff  [NS];
   erfinv_pkg::q_type   acc_ff   [NS];

   erfinv_pkg::q_type   poly;
   logic                vf_ff;
   logic                nonpos_ff;
   erfinv_pkg::tag_type tagf_ff;
   logic [63:0]         pm0_ff;
   logic [62:0]         pm1_ff;
   logic [95:0]         prod;
   logic [95:0]         scaled;
   logic                ovf;
   logic                sat_in;
   logic [erfinv_pkg::RES_W-1:0] result_in;
   logic                rsp_valid_ff;
   logic [erfinv_pkg::RES_W-1:0] result_ff;
   logic                sat_ff;

   for (genvar k = 0; k < NS; k++) begin : g_hor
      logic                v_src;
      logic                near_src;
      erfinv_pkg::q_type   d_src;
      erfinv_pkg::q_type   acc_src;
      erfinv_pkg::tag_type tag_src;
      erfinv_pkg::q_type   prod_y;

      if (k == 0) begin : g_first
         assign v_src    = in_valid;
         assign near_src = in_near;
         assign d_src    = in_d;
         assign tag_src  = in_tag;
         assign acc_src  = in_near ? erfinv_pkg::NEAR_Q[0] : erfinv_pkg::TAIL_Q[0];
      end else begin : g_next
         assign v_src    = vh_ff[k-1];
         assign near_src = nearh_ff[k-1];
         assign d_src    = dh_ff[k-1];
         assign tag_src  = tagh_ff[k-1];
         assign acc_src  = acc_ff[k-1];
      end

      erfinv_qmul u_mul (
         .clock (clock),
         .adv   (adv),
         .a     (acc_src),
         .b     (d_src),
         .y     (prod_y)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            v1_ff[k] <= 1'b0;
            v2_ff[k] <= 1'b0;
            vh_ff[k] <= 1'b0;
         end else if (adv) begin
            v1_ff[k] <= v_src;
            v2_ff[k] <= v1_ff[k];
            vh_ff[k] <= v2_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            near1_ff[k] <= near_src;
            near2_ff[k] <= near1_ff[k];
            nearh_ff[k] <= near2_ff[k];
            d1_ff[k]    <= d_src;
            d2_ff[k]    <= d1_ff[k];
            dh_ff[k]    <= d2_ff[k];
            tag1_ff[k]  <= tag_src;
            tag2_ff[k]  <= tag1_ff[k];
            tagh_ff[k]  <= tag2_ff[k];
            acc_ff[k]   <= (near2_ff[k] ? erfinv_pkg::NEAR_Q[k+1] : erfinv_pkg::TAIL_Q[k+1])
                         + prod_y;
         end
      end
   end

   assign poly = acc_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (adv) begin
         vf_ff <= vh_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nonpos_ff <= poly[63] | (poly == '0);
         tagf_ff   <= tagh_ff[NS-1];
         pm0_ff    <= poly[31:0]  * tagh_ff[NS-1].u;
         pm1_ff    <= poly[62:32] * tagh_ff[NS-1].u;
      end
   end

   assign prod   = {1'b0, pm1_ff, 32'd0} + {32'd0, pm0_ff} + (96'd1 << (SH - 1));
   assign scaled = prod >> SH;
   assign ovf    = |scaled[95:erfinv_pkg::RES_W];

   always_comb begin
      sat_in    = tagf_ff.sat | (!tagf_ff.zero && !nonpos_ff && ovf);
      result_in = scaled[erfinv_pkg::RES_W-1:0];
      if (sat_in) begin
         result_in = '1;
      end else if (tagf_ff.zero || nonpos_ff) begin
         result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff <= result_in;
         sat_ff    <= sat_in;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_result    = result_ff;
   assign out_saturated = sat_ff;

endmodule

[rtl/erfinv_checker.sv]
// Port-level checks of the inverse error function, bound to the top level.
module erfinv_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [erfinv_pkg::ARG_W-1:0]    req_arg_value,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [erfinv_pkg::RES_W-1:0]    rsp_result_value,
   input logic                            rsp_saturated
);

   // A saturated beat always carries the all-ones result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_result_value == '1)
      else $error("saturated beat without all-ones result");

   // An empty output register never blocks the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_saturated))
      else $error("stalled result beat changed");

   // A waiting request beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_arg_value))
      else $error("waiting request beat changed");

endmodule

bind inverse_error_function erfinv_checker u_erfinv_checker (.*);

[tb/sv/inverse_error_function_test.sv]
// Self-checking testbench of the inverse error function pipeline with its own predictor.
`timescale 1ns / 100ps

module inverse_error_function_test;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [erfinv_pkg::RES_W-1:0] value;
      logic                         sat;
   } erfinv_result_type;

   class erfinv_scoreboard;
      erfinv_pkg::q_type near_c[erfinv_pkg::TERMS];
      erfinv_pkg::q_type tail_c[erfinv_pkg::TERMS];
      erfinv_pkg::q_type ln2_c;
      erfinv_result_type pending[$];

      function erfinv_pkg::q_type to_fixed(bit neg, logic [63:0] mant, int exp10);
         logic [127:0] num, den, quo, rem;
         num = {64'd0, mant} << erfinv_pkg::QF;
         den = 128'd1;
         for (int i = 0; i < exp10; i++) den = den * 128'd10;
         quo = num / den;
         rem = num - quo * den;
         if (rem >= den - rem) quo = quo + 128'd1;
         return neg ? -erfinv_pkg::q_type'(quo[63:0]) : erfinv_pkg::q_type'(quo[63:0]);
      endfunction

      function new();
         logic [63:0] near_m[erfinv_pkg::TERMS] = '{281022636, 343273939, 352338770,
                                         439150654, 21858087, 125372503, 417768164,
                                         246640727, 150140941};
         int          near_e[erfinv_pkg::TERMS] = '{16, 15, 14, 14, 11, 11, 11, 9, 8};
         bit          near_n[erfinv_pkg::TERMS] = '{0, 0, 1, 1, 0, 1, 1, 0, 0};
         logic [63:0] tail_m[erfinv_pkg::TERMS] = '{200214257, 100950558, 134934322,
                                         367342844, 573950773, 76224613, 943887047,
                                         100167406, 283297682};
         int          tail_e[erfinv_pkg::TERMS] = '{12, 12, 11, 11, 11, 10, 11, 8, 8};
         bit          tail_n[erfinv_pkg::TERMS] = '{1, 0, 0, 1, 0, 1, 0, 0, 0};
         for (int i = 0; i < erfinv_pkg::TERMS; i++) begin
            near_c[i] = to_fixed(near_n[i], near_m[i], near_e[i]);
            tail_c[i] = to_fixed(tail_n[i], tail_m[i], tail_e[i]);
         end
         ln2_c = to_fixed(1'b0, 64'd6931471805599453, 16);
      endfunction

      function erfinv_pkg::q_type fix_mul(erfinv_pkg::q_type a, erfinv_pkg::q_type b);
         logic [63:0]       ua, ub;
         logic [127:0]      p;
         erfinv_pkg::q_type m;
         ua = a < 0 ? -a : a;
         ub = b < 0 ? -b : b;
         p = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (erfinv_pkg::QF - 1)))
             >> erfinv_pkg::QF;
         m = erfinv_pkg::q_type'({2'b00, p[61:0]});
         return ((a < 0) != (b < 0)) ? -m : m;
      endfunction

      function erfinv_pkg::q_type poly_eval(bit use_tail, erfinv_pkg::q_type d);
         erfinv_pkg::q_type acc;
         acc = use_tail ? tail_c[0] : near_c[0];
         for (int i = 1; i < erfinv_pkg::TERMS; i++)
            acc = (use_tail ? tail_c[i] : near_c[i]) + fix_mul(acc, d);
         return acc;
      endfunction

      function erfinv_result_type erfinv_of(logic [erfinv_pkg::ARG_W-1:0] arg);
         erfinv_result_type r;
         logic [63:0]       u, t, m, f, s, c;
         logic [127:0]      sq, rad, prod;
         erfinv_pkg::q_type w, poly;
         int                e;
         r.value = '0;
         r.sat = 1'b0;
         if (arg[erfinv_pkg::ARG_W-1]) begin
            r.value = '1;
            r.sat = 1'b1;
            return r;
         end
         u = {32'd0, arg[31:0]};
         if (u == 0) return r;
         t = 64'd0 - u * u;
         e = 0;
         for (int i = 0; i < 64; i++) if (t[i]) e = i;
         m = (e == 63) ? (t >> 1) : (t << (62 - e));
         f = '0;
         for (int i = 0; i < erfinv_pkg::QF; i++) begin
            sq = {64'd0, m} * {64'd0, m};
            m = sq[125:62];
            if (m[63]) begin
               f[erfinv_pkg::QF-1-i] = 1'b1;
               m = m >> 1;
            end
         end
         w = fix_mul(erfinv_pkg::q_type'((64'(64 - e) << erfinv_pkg::QF) - f), ln2_c);
         if (w < (erfinv_pkg::q_type'(5) <<< erfinv_pkg::QF)) begin
            poly = poly_eval(1'b0, w - (erfinv_pkg::q_type'(5) <<< (erfinv_pkg::QF - 1)));
         end else begin
            rad = {64'd0, w} << erfinv_pkg::QF;
            s = '0;
            for (int i = erfinv_pkg::ROOT_W - 1; i >= 0; i--) begin
               c = s | (64'd1 << i);
               if ({64'd0, c} * {64'd0, c} <= rad) s = c;
            end
            poly = poly_eval(1'b1, erfinv_pkg::q_type'(s)
                                   - (erfinv_pkg::q_type'(3) <<< erfinv_pkg::QF));
         end
         if (poly <= 0) return r;
         prod = ({64'd0, poly} * {64'd0, u} + (128'd1 << (erfinv_pkg::OUT_SHIFT - 1)))
                >> erfinv_pkg::OUT_SHIFT;
         if (prod > 128'hFFFF_FFFF) begin
            r.value = '1;
            r.sat = 1'b1;
         end else begin
            r.value = prod[31:0];
         end
         return r;
      endfunction

      function void note_arg(logic [erfinv_pkg::ARG_W-1:0] arg);
         pending.push_back(erfinv_of(arg));
      endfunction

      function bit check_result(logic [erfinv_pkg::RES_W-1:0] value, logic sat,
                                output string msg);
         erfinv_result_type x;
         if (pending.size() == 0) begin
            msg = $sformatf("unexpected result beat %h sat %b", value, sat);
            return 1'b0;
         end
         x = pending.pop_front();
         if (value !== x.value || sat !== x.sat) begin
            msg = $sformatf("result %h sat %b, expected %h sat %b",
                            value, sat, x.value, x.sat);
            return 1'b0;
         end
         return 1'b1;
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [erfinv_pkg::ARG_W-1:0] req_arg_value;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [erfinv_pkg::RES_W-1:0] rsp_result_value;
   logic                         rsp_saturated;

   erfinv_scoreboard sb = new();
   int  mismatches = 0;
   int  cycles = 0;
   int  results_seen = 0;

   inverse_error_function u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_arg_value(req_arg_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_saturated(rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (!sb.check_result(rsp_result_value, rsp_saturated, msg)) report(msg);
      end
   end

   // The receiver mixes steady, random and sparse acceptance, with one long hold-off.
   initial begin
      int mode;
      bit held;
      mode = 0;
      held = 1'b0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && results_seen >= 60) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (500) @(negedge clock);
         end
         if (cycles % 64 == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
         @(negedge clock);
      end
   end

   task automatic send_arg(logic [erfinv_pkg::ARG_W-1:0] arg);
      req_valid <= 1'b1;
      req_arg_value <= arg;
      do @(posedge clock); while (!req_ready);
      sb.note_arg(arg);
      @(negedge clock);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      req_arg_value <= {1'($urandom_range(0, 1)), 32'($urandom)};
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [erfinv_pkg::ARG_W-1:0] random_arg();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return {1'b0, 32'($urandom)};
      if (pick < 65) return {1'b0, 32'hFFFF_FFFF - ($urandom >> $urandom_range(0, 31))};
      if (pick < 80) return {1'b0, 32'($urandom >> $urandom_range(0, 31))};
      if (pick < 90) return {1'b0, 32'hFF22_D0E5 + $urandom_range(0, 2097152) - 32'd1048576};
      return {1'b1, 32'($urandom)};
   endfunction

   initial begin
      logic [erfinv_pkg::ARG_W-1:0] directed[$] = '{
         33'h0_0000_0000, 33'h0_0000_0001, 33'h0_0000_0002, 33'h0_8000_0000,
         33'h0_D9DA_0000, 33'h0_F000_0000, 33'h0_FF22_D0E5, 33'h0_FF22_0000,
         33'h0_FF23_8000, 33'h0_FFFF_0000, 33'h0_FFFF_FFFE, 33'h0_FFFF_FFFF,
         33'h1_0000_0000, 33'h1_0000_0001, 33'h1_FFFF_FFFF, 33'h0_5555_5555,
         33'h0_AAAA_AAAA, 33'h1_AAAA_AAAA, 33'h0_0001_0000, 33'h0_FFFF_F000
      };
      int sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_arg_value = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send_arg(directed[i]);
      sent = 0;
      while (sent < 450) begin
         int burst;
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++) begin
            send_arg(random_arg());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 10));
      end
      idle_gap(1);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
